>>> src/infix_to_prefix_converter_defines.svh
// ----------------------------------------------------------------------------
// infix_to_prefix_converter assertion macros
// shared concurrent assertion forms for the converter, clocked and reset-gated
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_PREFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_PREFIX_CONVERTER_DEFINES_SVH

// same-cycle implication
`define IFP_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ifp assertion failed");

// next-cycle implication
`define IFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ifp assertion failed");

`endif

>>> src/ifp_pkg.sv
// ----------------------------------------------------------------------------
// ifp_pkg
// character codes, status codes, precedence and controller/datapath structs
// ----------------------------------------------------------------------------
package ifp_pkg;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [1:0] STATUS_PAREN    = 2'd2;

  localparam logic [1:0] PREC_NONE = 2'd0;
  localparam logic [1:0] PREC_ADD  = 2'd1;
  localparam logic [1:0] PREC_MUL  = 2'd2;

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    p = PREC_NONE;
    if (c == CH_STAR || c == CH_SLASH) begin
      p = PREC_MUL;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      p = PREC_ADD;
    end
    return p;
  endfunction

  // controller to datapath
  typedef struct packed {
    logic load_en;      // input channel open
    logic scan_read;    // fetch next character from the end
    logic cur_load;     // latch fetched character
    logic push_cur;     // push latched operator
    logic push_fetch;   // push fetched character
    logic collect_top;  // append stack top to result
    logic collect_fetch;// append fetched character to result
    logic pop;          // drop stack top, read the one below
    logic refill;       // load stack top from memory
    logic emit_read;    // read next result character
    logic emit_load;    // load output register with result character
    logic err_load;     // load output register with error result
    logic err_paren;    // error kind for err_load
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_acc;
    logic in_last;
    logic ovf_hit;
    logic sidx_zero;
    logic depth_zero;
    logic depth_one;
    logic top_gt;
    logic top_is_rp;
    logic f_is_op;
    logic f_is_rp;
    logic f_is_lp;
    logic rcount_zero;
    logic out_free;
  } sts_t;

endpackage

>>> src/ifp_ram.sv
// ----------------------------------------------------------------------------
// ifp_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ifp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/ifp_ctrl.sv
// ----------------------------------------------------------------------------
// ifp_ctrl
// sequencer for load, reverse scan, stack flush and result emission
// ----------------------------------------------------------------------------
module ifp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  ifp_pkg::sts_t sts,
  output ifp_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_SCAN      = 4'd1;
  localparam logic [3:0] S_FETCH     = 4'd2;
  localparam logic [3:0] S_OP        = 4'd3;
  localparam logic [3:0] S_PAREN     = 4'd4;
  localparam logic [3:0] S_REFILL    = 4'd5;
  localparam logic [3:0] S_FLUSH     = 4'd6;
  localparam logic [3:0] S_EMIT      = 4'd7;
  localparam logic [3:0] S_EMIT_WAIT = 4'd8;
  localparam logic [3:0] S_ERR       = 4'd9;

  logic [3:0] state, state_next;
  logic [3:0] ret, ret_next;
  logic       err_paren, err_paren_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      err_paren <= 1'b0;
    end else begin
      state     <= state_next;
      ret       <= ret_next;
      err_paren <= err_paren_next;
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.err_paren  = err_paren;
    state_next     = state;
    ret_next       = ret;
    err_paren_next = err_paren;
    case (state)
      S_IDLE: begin
        cmd.load_en = 1'b1;
        if (sts.in_acc && sts.in_last) begin
          if (sts.ovf_hit) begin
            err_paren_next = 1'b0;
            state_next     = S_ERR;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sts.sidx_zero) begin
          state_next = S_FLUSH;
        end else begin
          cmd.scan_read = 1'b1;
          state_next    = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.cur_load = 1'b1;
        if (sts.f_is_op) begin
          state_next = S_OP;
        end else if (sts.f_is_rp) begin
          cmd.push_fetch = 1'b1;
          state_next     = S_SCAN;
        end else if (sts.f_is_lp) begin
          state_next = S_PAREN;
        end else begin
          cmd.collect_fetch = 1'b1;
          state_next        = S_SCAN;
        end
      end
      S_OP: begin
        if (!sts.depth_zero && sts.top_gt) begin
          cmd.collect_top = 1'b1;
          cmd.pop         = 1'b1;
          ret_next        = S_OP;
          state_next      = sts.depth_one ? S_OP : S_REFILL;
        end else begin
          cmd.push_cur = 1'b1;
          state_next   = S_SCAN;
        end
      end
      S_PAREN: begin
        if (sts.depth_zero) begin
          err_paren_next = 1'b1;
          state_next     = S_ERR;
        end else if (sts.top_is_rp) begin
          // matching close paren, both dropped
          cmd.pop    = 1'b1;
          ret_next   = S_SCAN;
          state_next = sts.depth_one ? S_SCAN : S_REFILL;
        end else begin
          cmd.collect_top = 1'b1;
          cmd.pop         = 1'b1;
          ret_next        = S_PAREN;
          state_next      = sts.depth_one ? S_PAREN : S_REFILL;
        end
      end
      S_REFILL: begin
        cmd.refill = 1'b1;
        state_next = ret;
      end
      S_FLUSH: begin
        if (sts.depth_zero) begin
          state_next = S_EMIT;
        end else if (sts.top_is_rp) begin
          err_paren_next = 1'b1;
          state_next     = S_ERR;
        end else begin
          cmd.collect_top = 1'b1;
          cmd.pop         = 1'b1;
          ret_next        = S_FLUSH;
          state_next      = sts.depth_one ? S_FLUSH : S_REFILL;
        end
      end
      S_EMIT: begin
        if (sts.rcount_zero) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit_read = 1'b1;
          state_next    = S_EMIT_WAIT;
        end
      end
      S_EMIT_WAIT: begin
        cmd.emit_load = 1'b1;
        state_next    = S_EMIT;
      end
      S_ERR: begin
        if (sts.out_free) begin
          cmd.err_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> src/ifp_datapath.sv
// ----------------------------------------------------------------------------
// ifp_datapath
// expression, stack and result memories, counters and output register
// ----------------------------------------------------------------------------
module ifp_datapath #(
  parameter int MAX_LEN = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  ifp_pkg::cmd_t cmd,
  output ifp_pkg::sts_t sts,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_char,
  input  logic          in_last,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_char,
  output logic          out_last,
  output logic [1:0]    status
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  logic [CW-1:0] expr_count;
  logic          overflow_seen;
  logic [CW-1:0] sidx;
  logic [CW-1:0] stack_depth;
  logic [CW-1:0] result_count;
  logic [7:0]    top;
  logic [7:0]    cur;

  logic          in_acc;
  logic          expr_full;
  logic [CW-1:0] sidx_m1;
  logic [CW-1:0] depth_m1;
  logic [CW-1:0] depth_m2;
  logic [CW-1:0] rcount_m1;
  logic [7:0]    expr_rdata;
  logic [7:0]    stack_rdata;
  logic [7:0]    result_rdata;
  logic [7:0]    push_data;
  logic [7:0]    collect_data;
  logic          do_push;
  logic          do_collect;
  logic          out_acc;

  assign in_stall   = !cmd.load_en;
  assign in_acc     = in_valid && !in_stall;
  assign out_acc    = out_valid && !out_stall;
  assign expr_full  = (expr_count == CW'(MAX_LEN));
  assign sidx_m1    = sidx - 1'b1;
  assign depth_m1   = stack_depth - 1'b1;
  assign depth_m2   = stack_depth - CW'(2);
  assign rcount_m1  = result_count - 1'b1;
  assign do_push    = cmd.push_cur || cmd.push_fetch;
  assign push_data  = cmd.push_fetch ? expr_rdata : cur;
  assign do_collect = cmd.collect_top || cmd.collect_fetch;
  assign collect_data = cmd.collect_fetch ? expr_rdata : top;

  ifp_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_expr_ram (
    .clk   (clk),
    .we    (in_acc && !expr_full),
    .waddr (expr_count[AW-1:0]),
    .wdata (in_char),
    .raddr (sidx_m1[AW-1:0]),
    .rdata (expr_rdata)
  );

  // holds every entry below the cached top
  ifp_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_stack_ram (
    .clk   (clk),
    .we    (do_push && (stack_depth != '0)),
    .waddr (depth_m1[AW-1:0]),
    .wdata (top),
    .raddr (depth_m2[AW-1:0]),
    .rdata (stack_rdata)
  );

  ifp_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_result_ram (
    .clk   (clk),
    .we    (do_collect),
    .waddr (result_count[AW-1:0]),
    .wdata (collect_data),
    .raddr (rcount_m1[AW-1:0]),
    .rdata (result_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      expr_count    <= '0;
      overflow_seen <= 1'b0;
      sidx          <= '0;
      stack_depth   <= '0;
      result_count  <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (in_acc) begin
        if (in_last) begin
          expr_count    <= '0;
          overflow_seen <= 1'b0;
          sidx          <= expr_full ? expr_count : expr_count + 1'b1;
        end else if (expr_full) begin
          overflow_seen <= 1'b1;
        end else begin
          expr_count <= expr_count + 1'b1;
        end
      end
      if (cmd.scan_read) begin
        sidx <= sidx_m1;
      end
      if (cmd.err_load) begin
        stack_depth <= '0;
      end else if (do_push) begin
        stack_depth <= stack_depth + 1'b1;
      end else if (cmd.pop) begin
        stack_depth <= depth_m1;
      end
      if (cmd.err_load) begin
        result_count <= '0;
      end else if (do_collect) begin
        result_count <= result_count + 1'b1;
      end else if (cmd.emit_read) begin
        result_count <= rcount_m1;
      end
      if (cmd.emit_load || cmd.err_load) begin
        out_valid <= 1'b1;
      end else if (out_acc) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.cur_load) begin
      cur <= expr_rdata;
    end
    if (do_push) begin
      top <= push_data;
    end else if (cmd.refill) begin
      top <= stack_rdata;
    end
    if (cmd.emit_load) begin
      out_char <= result_rdata;
      out_last <= (result_count == '0);
      status   <= ifp_pkg::STATUS_OK;
    end else if (cmd.err_load) begin
      out_char <= 8'h00;
      out_last <= 1'b1;
      status   <= cmd.err_paren ? ifp_pkg::STATUS_PAREN : ifp_pkg::STATUS_OVERFLOW;
    end
  end

  always_comb begin
    sts             = '0;
    sts.in_acc      = in_acc;
    sts.in_last     = in_last;
    sts.ovf_hit     = overflow_seen || expr_full;
    sts.sidx_zero   = (sidx == '0);
    sts.depth_zero  = (stack_depth == '0);
    sts.depth_one   = (stack_depth == CW'(1));
    sts.top_gt      = ifp_pkg::prec_of(top) > ifp_pkg::prec_of(cur);
    sts.top_is_rp   = (top == ifp_pkg::CH_RPAREN);
    sts.f_is_op     = (ifp_pkg::prec_of(expr_rdata) != ifp_pkg::PREC_NONE);
    sts.f_is_rp     = (expr_rdata == ifp_pkg::CH_RPAREN);
    sts.f_is_lp     = (expr_rdata == ifp_pkg::CH_LPAREN);
    sts.rcount_zero = (result_count == '0);
    sts.out_free    = !out_valid || !out_stall;
  end

endmodule

>>> src/infix_to_prefix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_prefix_converter
// converts a stored infix expression into prefix form with an operator stack
// ----------------------------------------------------------------------------
// The block takes an infix expression one character per input transfer,
// in_last closing it. Up to MAX_LEN characters, the last one too, are
// written into the expression memory; the input then stalls until the whole
// conversion and emission is done. The stored text is scanned from its end,
// each character with a memory read, then a decision, and an operator or a
// '(' with one more step, with '*' '/' above '+' '-'; every further operator
// popped off the stack costs a pop, then a registered read of the entry
// below the cached top, skipped when the stack runs empty. The result memory
// is then read backwards, a read and then a load of the output register per
// output transfer, held for as long as the receiver holds stall.
// More than MAX_LEN characters give one result with status 1, unbalanced
// parentheses one with status 2, both with out_char zero and out_last set;
// an expression of balanced parentheses only gives no result at all.
// ----------------------------------------------------------------------------
`include "infix_to_prefix_converter_defines.svh"

module infix_to_prefix_converter #(
  parameter int MAX_LEN = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_last,
  output logic [1:0] status
);

  ifp_pkg::cmd_t cmd;
  ifp_pkg::sts_t sts;
  logic          err_shown;

  // sequencer
  ifp_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // memories, stack top cache, counters and output register
  ifp_datapath #(.MAX_LEN(MAX_LEN)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_char   (in_char),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .out_last  (out_last),
    .status    (status)
  );

  // an error result sitting on the output
  assign err_shown = out_valid && (status != ifp_pkg::STATUS_OK);

  // error results are single, last and carry no character
  `IFP_ASSERT_SAME(a_err_shape, clk, rst, err_shown, out_last && (out_char == 8'h00))

  // no stack traffic while the input channel is open
  `IFP_ASSERT_SAME(a_load_quiet, clk, rst, !in_stall, !(cmd.push_cur || cmd.push_fetch || cmd.pop))

  // a result read is only started when the output register frees up
  `IFP_ASSERT_SAME(a_emit_room, clk, rst, cmd.emit_read, sts.out_free)

  // an error load always shows up as a pending last transfer
  `IFP_ASSERT_NEXT(a_err_out, clk, rst, cmd.err_load, out_valid && out_last)

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the infix to prefix converter
// ----------------------------------------------------------------------------
// Expressions go in one character per transfer. Each accepted character also
// goes into a local converter that keeps its own expression store and works out
// the prefix text for the expression when the last character is seen. Every
// output transfer is checked field by field against the oldest predicted
// result. Directed expressions come first: precedence, parentheses, the error
// cases, byte extremes and the length limit. Random expressions follow, most of
// them well formed, with random gaps on the sender and random stall on the
// receiver. One long receiver hold-off makes the block back up into its input.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int EXPR_DEPTH   = 64;
  localparam int RANDOM_ITEMS = 40;
  localparam int IDLE_LIMIT   = 4000;  // cycles with no transfer at all
  localparam int LONG_HOLD    = 600;   // receiver hold-off for back pressure
  localparam int DRAIN_CYCLES = 400;   // quiet time after the last result

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_xfer_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic [1:0] st;
  } prefix_res_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char;
  logic       out_last;
  logic [1:0] status;

  // stimulus and prediction stores
  char_xfer_t  pending_chars[$];
  logic [7:0]  expr_build[$];
  prefix_res_t expected_prefix[$];
  logic [7:0]  held_expr[$];
  logic        held_overflow = 1'b0;
  logic [7:0]  op_stack[$];
  logic [7:0]  rev_out[$];

  // handshake bookkeeping, updated at the rising edge
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  int   taken_count = 0;
  int   total_count = 0;
  int   results_seen = 0;
  int   idle_cycles = 0;
  int   fail_count = 0;

  // sender and receiver pacing
  int   send_gap = 0;
  bit   send_calm = 1'b0;
  int   recv_wait = 0;
  int   wait_now;
  bit   recv_calm = 1'b0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  logic hold_on;

  char_xfer_t  nxt;
  prefix_res_t want;

  assign hold_on = (hold_left != 0);

  infix_to_prefix_converter #(
    .MAX_LEN(EXPR_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_char  (in_char),
    .in_last  (in_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_char (out_char),
    .out_last (out_last),
    .status   (status)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- helpers

  // '*' '/' bind tighter than '+' '-', everything else is not an operator
  function automatic int op_rank(input logic [7:0] c);
    if (c == ifp_pkg::CH_STAR || c == ifp_pkg::CH_SLASH) begin
      return 2;
    end else if (c == ifp_pkg::CH_PLUS || c == ifp_pkg::CH_MINUS) begin
      return 1;
    end
    return 0;
  endfunction

  function automatic logic [7:0] pick_operand();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (op_rank(c) != 0 || c == ifp_pkg::CH_LPAREN || c == ifp_pkg::CH_RPAREN) begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 3))
      0: return ifp_pkg::CH_PLUS;
      1: return ifp_pkg::CH_MINUS;
      2: return ifp_pkg::CH_STAR;
      default: return ifp_pkg::CH_SLASH;
    endcase
  endfunction

  // one line per mismatch
  task automatic report_mismatch(input string what, input int got, input int exp_val);
    fail_count++;
    $display("mismatch on %s at result %0d: got %0h, wanted %0h",
             what, results_seen, got, exp_val);
  endtask

  // ------------------------------------------------------- expression build

  task automatic add_text(input string s);
    int k;
    for (k = 0; k < s.len(); k++) begin
      expr_build.push_back(s[k]);
    end
  endtask

  // hand the built expression to the driver, last flag on its final character
  task automatic queue_expr();
    int k;
    char_xfer_t x;
    for (k = 0; k < expr_build.size(); k++) begin
      x.ch   = expr_build[k];
      x.last = (k == expr_build.size() - 1);
      pending_chars.push_back(x);
    end
    expr_build.delete();
  endtask

  // random well formed infix text with nested parentheses
  task automatic gen_wellformed(input int n_operands);
    int k;
    int depth;
    depth = 0;
    for (k = 0; k < n_operands; k++) begin
      while ($urandom_range(0, 3) == 0 && depth < 4) begin
        expr_build.push_back(ifp_pkg::CH_LPAREN);
        depth++;
      end
      expr_build.push_back(pick_operand());
      while (depth > 0 && $urandom_range(0, 2) == 0) begin
        expr_build.push_back(ifp_pkg::CH_RPAREN);
        depth--;
      end
      if (k < n_operands - 1) begin
        expr_build.push_back(pick_operator());
      end
    end
    while (depth > 0) begin
      expr_build.push_back(ifp_pkg::CH_RPAREN);
      depth--;
    end
  endtask

  // any mix of operators, parentheses and raw bytes
  task automatic gen_noise(input int len);
    int k;
    for (k = 0; k < len; k++) begin
      case ($urandom_range(0, 3))
        0: expr_build.push_back(ifp_pkg::CH_LPAREN);
        1: expr_build.push_back(ifp_pkg::CH_RPAREN);
        2: expr_build.push_back(pick_operator());
        default: expr_build.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // ------------------------------------------------------------- prediction

  // reverse scan with an operator stack; balanced is cleared on a stray paren
  task automatic scan_reversed(output bit balanced);
    int i;
    logic [7:0] c;
    logic [7:0] t;
    bit matched;
    op_stack.delete();
    rev_out.delete();
    balanced = 1'b1;
    for (i = held_expr.size() - 1; i >= 0 && balanced; i--) begin
      c = held_expr[i];
      if (op_rank(c) != 0) begin
        // only strictly tighter operators leave the stack
        while (op_stack.size() > 0 &&
               op_rank(op_stack[op_stack.size() - 1]) > op_rank(c)) begin
          rev_out.push_back(op_stack.pop_back());
        end
        op_stack.push_back(c);
      end else if (c == ifp_pkg::CH_RPAREN) begin
        op_stack.push_back(c);
      end else if (c == ifp_pkg::CH_LPAREN) begin
        matched = 1'b0;
        while (op_stack.size() > 0 && !matched) begin
          t = op_stack.pop_back();
          if (t == ifp_pkg::CH_RPAREN) begin
            matched = 1'b1;
          end else begin
            rev_out.push_back(t);
          end
        end
        if (!matched) begin
          balanced = 1'b0;
        end
      end else begin
        rev_out.push_back(c);
      end
    end
    while (balanced && op_stack.size() > 0) begin
      t = op_stack.pop_back();
      if (t == ifp_pkg::CH_RPAREN) begin
        balanced = 1'b0;
      end else begin
        rev_out.push_back(t);
      end
    end
  endtask

  // one accepted character: store it, and on the last one predict the results
  task automatic predict_transfer(input char_xfer_t x);
    bit balanced;
    int k;
    prefix_res_t r;
    if (held_expr.size() < EXPR_DEPTH) begin
      held_expr.push_back(x.ch);
    end else begin
      held_overflow = 1'b1;
    end
    if (x.last) begin
      if (held_overflow) begin
        // too long wins over any paren problem
        r.ch = 8'h00; r.last = 1'b1; r.st = ifp_pkg::STATUS_OVERFLOW;
        expected_prefix.push_back(r);
      end else begin
        scan_reversed(balanced);
        if (!balanced) begin
          r.ch = 8'h00; r.last = 1'b1; r.st = ifp_pkg::STATUS_PAREN;
          expected_prefix.push_back(r);
        end else begin
          // parentheses only gives nothing at all
          for (k = rev_out.size() - 1; k >= 0; k--) begin
            r.ch = rev_out[k]; r.last = (k == 0); r.st = ifp_pkg::STATUS_OK;
            expected_prefix.push_back(r);
          end
        end
      end
      held_expr.delete();
      held_overflow = 1'b0;
    end
  endtask

  // ----------------------------------------------------------------- driver

  // changes at the falling edge; a payload under stall is left alone
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // still waiting for the transfer
    end else if (send_gap != 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_chars.size() != 0) begin
      nxt = pending_chars.pop_front();
      in_char  <= nxt.ch;
      in_last  <= nxt.last;
      in_valid <= 1'b1;
      if ($urandom_range(0, 15) == 0) begin
        send_calm = !send_calm;
      end
      send_gap <= send_calm ? 0 : $urandom_range(0, 17);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver stall, random per result plus the one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_wait <= 0;
    end else begin
      wait_now = recv_wait;
      if (out_fire) begin
        if ($urandom_range(0, 15) == 0) begin
          recv_calm = !recv_calm;
        end
        wait_now = recv_calm ? 0 : $urandom_range(0, 17);
      end
      out_stall <= hold_on || (wait_now != 0);
      recv_wait <= (wait_now != 0) ? wait_now - 1 : 0;
    end
  end

  // long hold-off, started once results are flowing; the sender keeps going
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && results_seen >= 20 && out_valid) begin
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    if (rst) begin
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire  <= in_valid && !in_stall;
      out_fire <= out_valid && !out_stall;
      if (in_valid && !in_stall) begin
        predict_transfer('{ch: in_char, last: in_last});
        taken_count <= taken_count + 1;
      end
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_prefix.size() == 0) begin
          report_mismatch("unexpected result", out_char, 0);
        end else begin
          want = expected_prefix.pop_front();
          if (out_char !== want.ch) begin
            report_mismatch("out_char", out_char, want.ch);
          end
          if (out_last !== want.last) begin
            report_mismatch("out_last", out_last, want.last);
          end
          if (status !== want.st) begin
            report_mismatch("status", status, want.st);
          end
        end
      end
    end
  end

  // watchdog: too long without any transfer on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ------------------------------------------------------- stimulus and end

  initial begin : stimulus
    int k;
    int kind;
    logic [7:0] paren_ch;

    // precedence and associativity
    add_text("a+b*c");       queue_expr();
    add_text("a-b-c");       queue_expr();
    add_text("a*b/c-d");     queue_expr();
    // parentheses, nested and redundant
    add_text("(a+b)*c");     queue_expr();
    add_text("a/(b-c)*d");   queue_expr();
    add_text("((x))");       queue_expr();
    // single operand and a lone operator
    add_text("x");           queue_expr();
    add_text("+");           queue_expr();
    // parentheses only: no result at all
    add_text("()");          queue_expr();
    // unmatched open, unmatched close, both wrong way round
    add_text("(a+b");        queue_expr();
    add_text("a+b)");        queue_expr();
    add_text(")(");          queue_expr();
    // byte extremes as operands
    expr_build.push_back(8'hFF);
    expr_build.push_back(ifp_pkg::CH_STAR);
    expr_build.push_back(8'h00);
    queue_expr();
    expr_build.push_back(8'h00);
    queue_expr();
    // exactly full: 64 operands, 64 results
    for (k = 0; k < EXPR_DEPTH; k++) begin
      expr_build.push_back(8'(8'h41 + (k % 26)));
    end
    queue_expr();
    // one past full, then overflow together with a stray paren
    for (k = 0; k <= EXPR_DEPTH; k++) begin
      expr_build.push_back(8'(8'h61 + (k % 26)));
    end
    queue_expr();
    for (k = 0; k < EXPR_DEPTH + 5; k++) begin
      expr_build.push_back(8'(8'h30 + (k % 10)));
    end
    expr_build.push_back(ifp_pkg::CH_LPAREN);
    queue_expr();
    // recovery right after an overflow
    add_text("a+b*c-d/e");   queue_expr();

    // random part: mostly well formed, some broken, some noise, a few long
    k = pending_chars.size() + RANDOM_ITEMS;
    while (pending_chars.size() < k) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        gen_wellformed($urandom_range(1, 6));
      end else if (kind < 82) begin
        gen_wellformed($urandom_range(1, 5));
        paren_ch = $urandom_range(0, 1) ? ifp_pkg::CH_LPAREN : ifp_pkg::CH_RPAREN;
        expr_build.insert($urandom_range(0, expr_build.size()), paren_ch);
      end else if (kind < 97) begin
        gen_noise($urandom_range(1, 10));
      end else begin
        // near the length limit, either side of it
        gen_wellformed($urandom_range(28, 36));
      end
      queue_expr();
    end
    total_count = pending_chars.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (taken_count != total_count) begin
      @(posedge clk);
    end
    while (expected_prefix.size() != 0) begin
      @(posedge clk);
    end
    // anything extra from the block shows up here as an unexpected result
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
